/* rtl/lcdrf_pkg.sv */
package lcdrf_pkg;

  // Command codes carried in the cmd field of an input beat.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Variant codes of the configuration register.
  localparam logic [1:0] VAR_BASE     = 2'd0;
  localparam logic [1:0] VAR_BOARD    = 2'd1;
  localparam logic [1:0] VAR_EXTENDED = 2'd2;

  // Word indexes (offset bits 11:2) of the control registers.
  localparam logic [9:0] REG_TIMING0 = 10'd0;
  localparam logic [9:0] REG_TIMING1 = 10'd1;
  localparam logic [9:0] REG_TIMING2 = 10'd2;
  localparam logic [9:0] REG_TIMING3 = 10'd3;
  localparam logic [9:0] REG_UPBASE  = 10'd4;
  localparam logic [9:0] REG_LPBASE  = 10'd5;
  localparam logic [9:0] REG_SLOT6   = 10'd6;
  localparam logic [9:0] REG_SLOT7   = 10'd7;
  localparam logic [9:0] REG_RIS     = 10'd8;
  localparam logic [9:0] REG_MIS     = 10'd9;
  localparam logic [9:0] REG_ICR     = 10'd10;
  localparam logic [9:0] REG_UPCUR   = 10'd11;
  localparam logic [9:0] REG_LPCUR   = 10'd12;

  // Offset bits 11:9 that select the palette window, bits 11:5 the ID window.
  localparam logic [2:0] PAL_WINDOW = 3'b001;
  localparam logic [6:0] ID_WINDOW  = 7'h7f;

  localparam int unsigned PAL_DEPTH = 128;
  localparam int unsigned PAL_AW    = 7;

  // Control word bits and status bits.
  localparam int unsigned CTRL_ENABLE_BIT = 0;
  localparam int unsigned CTRL_POWER_BIT  = 11;
  localparam logic [3:0]  STAT_NEXT_BASE  = 4'h4;
  localparam logic [3:0]  STAT_VCOMPARE   = 4'h8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic [10:0] width_pixels;
    logic [10:0] height_lines;
    logic        display_on;
    logic [2:0]  pixel_format;
    logic        vblank_armed;
  } out_item_t;

  // Identification bytes; the extended controller differs in two of them.
  function automatic logic [7:0] id_byte(input logic ext, input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = ext ? 8'h11 : 8'h10;
      3'd1:    b = 8'h11;
      3'd2:    b = ext ? 8'h24 : 8'h04;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h0d;
      3'd5:    b = 8'hf0;
      3'd6:    b = 8'h05;
      default: b = 8'hb1;
    endcase
    return b;
  endfunction

endpackage

/* rtl/lcd_controller_register_file_unit.sv */
// Register file of a color LCD controller. Each input beat is a bus read, a
// bus write or a vertical-blank tick, and each produces exactly one output
// beat carrying the read data (zero for writes and ticks), the interrupt
// line and the decoded display settings as they stand after that beat. Bus
// writes and ticks update the registers at the edge where the input beat is
// accepted; the 128-word palette lives in a synchronous RAM whose read port
// is registered, so every beat passes through a response stage before it
// reaches the output register. A new beat is taken in the same cycle as the
// previous one moves to the output register, so the block sustains one beat
// per cycle while the output side keeps taking beats; a stalled output holds
// the response stage, and input is then stalled after one beat. The palette
// reads as zero until an entry is written: a valid bit per entry, cleared by
// reset, stands in for clearing the RAM, so no clearing pass is needed. The
// variant register (written through cfg_we_i; the user must do so only while
// the block is idle, which is not enforced) selects the ID bytes and, for
// any nonzero value, swaps the mask and control offsets. Writes to unknown
// or read-only offsets are ignored and reads of unknown offsets return zero.
module lcd_controller_register_file_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lcdrf_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcdrf_pkg::out_item_t out_item_o
);

  // Configuration and register state.
  logic [1:0]  variant_q;
  logic [31:0] timing_q [4];
  logic [31:0] upbase_q, lpbase_q, control_q, mask_q;
  logic [3:0]  status_q;
  logic [10:0] width_q, height_q;
  logic        armed_q;

  // Palette RAM and its per-entry valid bits.
  logic [31:0]                   pal_mem [lcdrf_pkg::PAL_DEPTH];
  logic [lcdrf_pkg::PAL_DEPTH-1:0] pal_valid_q;
  logic [31:0]                   pal_rdata_q;
  logic                          pal_hit_q;

  // Response stage and output register.
  logic        busy_q;
  logic        pal_sel_q;
  logic [31:0] reg_rdata_q;
  logic        out_valid_q;
  lcdrf_pkg::out_item_t out_q;

  logic        in_fire, load_out;
  logic        is_read, is_write, is_tick;
  logic        swapped, in_pal, in_id;
  logic [9:0]  word_idx;
  logic [lcdrf_pkg::PAL_AW-1:0] pal_addr;
  logic [31:0] reg_rdata;
  logic [31:0] wdata;
  logic        ctrl_wr, mask_wr;

  // The response stage hands its beat on when the output register is free
  // or is being emptied; a new input beat can enter in that same cycle.
  assign load_out   = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !load_out;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign is_read  = in_item_i.cmd == lcdrf_pkg::CMD_READ;
  assign is_write = in_item_i.cmd == lcdrf_pkg::CMD_WRITE;
  assign is_tick  = in_item_i.cmd == lcdrf_pkg::CMD_TICK;
  assign wdata    = in_item_i.write_data;

  assign swapped  = variant_q != lcdrf_pkg::VAR_BASE;
  assign word_idx = in_item_i.offset[11:2];
  assign in_pal   = in_item_i.offset[11:9] == lcdrf_pkg::PAL_WINDOW;
  assign in_id    = in_item_i.offset[11:5] == lcdrf_pkg::ID_WINDOW;
  assign pal_addr = in_item_i.offset[lcdrf_pkg::PAL_AW+1:2];

  // Offset six is the mask on the base controller and the control word on
  // the other variants; offset seven is the opposite.
  assign ctrl_wr = is_write && !in_pal &&
                   ((word_idx == lcdrf_pkg::REG_SLOT6 && swapped) ||
                    (word_idx == lcdrf_pkg::REG_SLOT7 && !swapped));
  assign mask_wr = is_write && !in_pal &&
                   ((word_idx == lcdrf_pkg::REG_SLOT6 && !swapped) ||
                    (word_idx == lcdrf_pkg::REG_SLOT7 && swapped));

  // Read data of everything except the palette, taken from the registers
  // before the edge; a read changes no state, so this is also after it.
  always_comb begin
    reg_rdata = '0;
    if (in_id) begin
      reg_rdata = {24'd0,
                   lcdrf_pkg::id_byte(variant_q == lcdrf_pkg::VAR_EXTENDED,
                                      in_item_i.offset[4:2])};
    end else if (!in_pal) begin
      unique case (word_idx)
        lcdrf_pkg::REG_TIMING0: reg_rdata = timing_q[0];
        lcdrf_pkg::REG_TIMING1: reg_rdata = timing_q[1];
        lcdrf_pkg::REG_TIMING2: reg_rdata = timing_q[2];
        lcdrf_pkg::REG_TIMING3: reg_rdata = timing_q[3];
        lcdrf_pkg::REG_UPBASE:  reg_rdata = upbase_q;
        lcdrf_pkg::REG_LPBASE:  reg_rdata = lpbase_q;
        lcdrf_pkg::REG_SLOT6:   reg_rdata = swapped ? control_q : mask_q;
        lcdrf_pkg::REG_SLOT7:   reg_rdata = swapped ? mask_q : control_q;
        lcdrf_pkg::REG_RIS:     reg_rdata = {28'd0, status_q};
        lcdrf_pkg::REG_MIS:     reg_rdata = {28'd0, status_q & mask_q[3:0]};
        lcdrf_pkg::REG_UPCUR:   reg_rdata = upbase_q;
        lcdrf_pkg::REG_LPCUR:   reg_rdata = lpbase_q;
        default:                reg_rdata = '0;
      endcase
    end
  end

  // Palette RAM: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_fire && is_write && in_pal) begin
      pal_mem[pal_addr] <= wdata;
    end
    if (in_fire && is_read && in_pal) begin
      pal_rdata_q <= pal_mem[pal_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q <= '0;
      pal_hit_q   <= 1'b0;
    end else if (in_fire) begin
      if (is_write && in_pal) begin
        pal_valid_q[pal_addr] <= 1'b1;
      end
      pal_hit_q <= pal_valid_q[pal_addr];
    end
  end

  // Register updates at the edge that accepts a beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q   <= lcdrf_pkg::VAR_BASE;
      timing_q[0] <= '0;
      timing_q[1] <= '0;
      timing_q[2] <= '0;
      timing_q[3] <= '0;
      upbase_q    <= '0;
      lpbase_q    <= '0;
      control_q   <= '0;
      mask_q      <= '0;
      status_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      armed_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        variant_q <= cfg_wdata_i;
      end
      if (in_fire && is_write && !in_pal) begin
        unique case (word_idx)
          lcdrf_pkg::REG_TIMING0: begin
            timing_q[0] <= wdata;
            width_q     <= {7'({1'b0, wdata[7:2]}) + 7'd1, 4'b0000};
          end
          lcdrf_pkg::REG_TIMING1: begin
            timing_q[1] <= wdata;
            height_q    <= 11'({1'b0, wdata[9:0]}) + 11'd1;
          end
          lcdrf_pkg::REG_TIMING2: timing_q[2] <= wdata;
          lcdrf_pkg::REG_TIMING3: timing_q[3] <= wdata;
          lcdrf_pkg::REG_UPBASE:  upbase_q    <= wdata;
          lcdrf_pkg::REG_LPBASE:  lpbase_q    <= wdata;
          lcdrf_pkg::REG_ICR:     status_q    <= status_q & ~wdata[3:0];
          default: ;
        endcase
      end
      if (in_fire && ctrl_wr) begin
        control_q <= wdata;
        armed_q   <= wdata[lcdrf_pkg::CTRL_ENABLE_BIT] &&
                     wdata[lcdrf_pkg::CTRL_POWER_BIT];
      end
      if (in_fire && mask_wr) begin
        mask_q <= wdata;
      end
      if (in_fire && is_tick && armed_q) begin
        status_q <= status_q | lcdrf_pkg::STAT_NEXT_BASE | lcdrf_pkg::STAT_VCOMPARE;
      end
    end
  end

  // Response stage: holds the non-palette read data while the palette RAM
  // delivers its word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (load_out) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pal_sel_q   <= is_read && in_pal;
      reg_rdata_q <= is_read ? reg_rdata : '0;
    end
  end

  // Output register. The status fields are sampled from the registers as
  // they stand when the beat leaves the response stage; no later beat has
  // touched them yet, because the next beat updates them at this same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.read_data    <= pal_sel_q ? (pal_hit_q ? pal_rdata_q : '0) : reg_rdata_q;
      out_q.irq          <= |(status_q & mask_q[3:0]);
      out_q.width_pixels <= width_q;
      out_q.height_lines <= height_q;
      out_q.display_on   <= control_q[lcdrf_pkg::CTRL_ENABLE_BIT] &&
                            control_q[lcdrf_pkg::CTRL_POWER_BIT];
      out_q.pixel_format <= control_q[3:1];
      out_q.vblank_armed <= armed_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* verif/tb_lcd_controller_register_file_unit.sv */
module tb_lcd_controller_register_file_unit;

  // The command and variant codes that the package leaves unnamed.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] VAR_SPARE  = 2'd3;

  // Identification bytes, lowest byte first; the extended part differs in two.
  localparam logic [63:0] ID_STD_BYTES = 64'hb1_05_f0_0d_00_04_11_10;
  localparam logic [63:0] ID_EXT_BYTES = 64'hb1_05_f0_0d_00_24_11_11;

  localparam logic [31:0] CTRL_ON = (32'd1 << lcdrf_pkg::CTRL_ENABLE_BIT) |
                                    (32'd1 << lcdrf_pkg::CTRL_POWER_BIT);
  localparam int unsigned PHASE_REQS  = 230;
  localparam int unsigned CYCLE_LIMIT = 100000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  lcdrf_pkg::in_item_t in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lcdrf_pkg::out_item_t out_item_o;

  lcd_controller_register_file_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be offered on the input side, and the response beats
  // that accepted requests are still owed, oldest first.
  lcdrf_pkg::in_item_t  req_todo_q[$];
  lcdrf_pkg::out_item_t resp_due_q[$];

  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned reqs_queued   = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;

  // Shadow copy of the register file. It is advanced once per accepted
  // request beat, which is exactly the order in which the block applies them.
  logic [1:0]  cur_variant = lcdrf_pkg::VAR_BASE;
  logic [31:0] timing_shadow [4];
  logic [31:0] upbase_shadow = '0;
  logic [31:0] lpbase_shadow = '0;
  logic [31:0] ctrl_shadow   = '0;
  logic [31:0] mask_shadow   = '0;
  logic [3:0]  status_shadow = '0;
  logic [10:0] width_shadow  = '0;
  logic [10:0] height_shadow = '0;
  logic        armed_shadow  = 1'b0;
  logic [31:0] pal_shadow [lcdrf_pkg::PAL_DEPTH];

  initial begin
    for (int i = 0; i < 4; i++) timing_shadow[i] = '0;
    for (int i = 0; i < lcdrf_pkg::PAL_DEPTH; i++) pal_shadow[i] = '0;
  end

  // Applies one request to the shadow registers and returns the response
  // beat that the block must produce for it.
  function automatic lcdrf_pkg::out_item_t regfile_apply(input lcdrf_pkg::in_item_t req);
    logic [9:0]  word;
    logic [31:0] rd;
    logic        swapped;
    lcdrf_pkg::out_item_t resp;
    word    = req.offset[11:2];
    rd      = '0;
    swapped = (cur_variant != lcdrf_pkg::VAR_BASE);
    case (req.cmd)
      lcdrf_pkg::CMD_READ: begin
        if (req.offset[11:5] == lcdrf_pkg::ID_WINDOW) begin
          rd[7:0] = (cur_variant == lcdrf_pkg::VAR_EXTENDED)
                    ? ID_EXT_BYTES[8*req.offset[4:2] +: 8]
                    : ID_STD_BYTES[8*req.offset[4:2] +: 8];
        end else if (req.offset[11:9] == lcdrf_pkg::PAL_WINDOW) begin
          rd = pal_shadow[req.offset[8:2]];
        end else begin
          case (word)
            lcdrf_pkg::REG_TIMING0, lcdrf_pkg::REG_TIMING1,
            lcdrf_pkg::REG_TIMING2, lcdrf_pkg::REG_TIMING3: rd = timing_shadow[word[1:0]];
            lcdrf_pkg::REG_UPBASE, lcdrf_pkg::REG_UPCUR: rd = upbase_shadow;
            lcdrf_pkg::REG_LPBASE, lcdrf_pkg::REG_LPCUR: rd = lpbase_shadow;
            lcdrf_pkg::REG_SLOT6: rd = swapped ? ctrl_shadow : mask_shadow;
            lcdrf_pkg::REG_SLOT7: rd = swapped ? mask_shadow : ctrl_shadow;
            lcdrf_pkg::REG_RIS:   rd = {28'd0, status_shadow};
            lcdrf_pkg::REG_MIS:   rd = {28'd0, status_shadow & mask_shadow[3:0]};
            default:              rd = '0;
          endcase
        end
      end
      lcdrf_pkg::CMD_WRITE: begin
        if (req.offset[11:9] == lcdrf_pkg::PAL_WINDOW) begin
          pal_shadow[req.offset[8:2]] = req.write_data;
        end else begin
          case (word)
            lcdrf_pkg::REG_TIMING0: begin
              timing_shadow[0] = req.write_data;
              width_shadow = ({3'd0, req.write_data[7:2], 2'b00} + 11'd4) << 2;
            end
            lcdrf_pkg::REG_TIMING1: begin
              timing_shadow[1] = req.write_data;
              height_shadow = {1'b0, req.write_data[9:0]} + 11'd1;
            end
            lcdrf_pkg::REG_TIMING2: timing_shadow[2] = req.write_data;
            lcdrf_pkg::REG_TIMING3: timing_shadow[3] = req.write_data;
            lcdrf_pkg::REG_UPBASE:  upbase_shadow = req.write_data;
            lcdrf_pkg::REG_LPBASE:  lpbase_shadow = req.write_data;
            lcdrf_pkg::REG_SLOT6, lcdrf_pkg::REG_SLOT7: begin
              // The swap moves control to slot 6 for every nonzero variant.
              if (swapped == (word == lcdrf_pkg::REG_SLOT6)) begin
                ctrl_shadow  = req.write_data;
                armed_shadow = req.write_data[lcdrf_pkg::CTRL_ENABLE_BIT] &
                               req.write_data[lcdrf_pkg::CTRL_POWER_BIT];
              end else begin
                mask_shadow = req.write_data;
              end
            end
            lcdrf_pkg::REG_ICR: status_shadow = status_shadow & ~req.write_data[3:0];
            default: ;
          endcase
        end
      end
      lcdrf_pkg::CMD_TICK: begin
        if (armed_shadow) begin
          status_shadow = status_shadow | lcdrf_pkg::STAT_NEXT_BASE |
                          lcdrf_pkg::STAT_VCOMPARE;
        end
      end
      default: ;
    endcase
    resp.read_data    = rd;
    resp.irq          = |(status_shadow & mask_shadow[3:0]);
    resp.width_pixels = width_shadow;
    resp.height_lines = height_shadow;
    resp.display_on   = ctrl_shadow[lcdrf_pkg::CTRL_ENABLE_BIT] &
                        ctrl_shadow[lcdrf_pkg::CTRL_POWER_BIT];
    resp.pixel_format = ctrl_shadow[3:1];
    resp.vblank_armed = armed_shadow;
    return resp;
  endfunction

  function automatic lcdrf_pkg::in_item_t make_req(input logic [1:0] cmd,
                                                   input logic [11:0] off,
                                                   input logic [31:0] data);
    lcdrf_pkg::in_item_t req;
    req.cmd        = cmd;
    req.offset     = off;
    req.write_data = data;
    return req;
  endfunction

  // Data words lean toward the two extremes.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(3, 0))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // One random request: mostly register and palette traffic, some ticks and
  // ID reads, and a share of raw noise over the whole window and all commands.
  function automatic lcdrf_pkg::in_item_t rand_req();
    int unsigned pick;
    logic [9:0]  word;
    logic [1:0]  rw;
    pick = $urandom_range(99, 0);
    word = 10'($urandom_range(12, 0));
    rw   = $urandom_range(1, 0) ? lcdrf_pkg::CMD_WRITE : lcdrf_pkg::CMD_READ;
    if (pick < 10) return make_req(2'($urandom_range(3, 0)), 12'($urandom()), $urandom());
    if (pick < 18) return make_req(lcdrf_pkg::CMD_TICK, 12'($urandom()), $urandom());
    if (pick < 32) return make_req(rw, {lcdrf_pkg::PAL_WINDOW, 9'($urandom())}, rand_word());
    if (pick < 38) begin
      return make_req(lcdrf_pkg::CMD_READ, {lcdrf_pkg::ID_WINDOW, 5'($urandom())}, $urandom());
    end
    return make_req(rw, {word, 2'($urandom())}, rand_word());
  endfunction

  task automatic queue_req(input lcdrf_pkg::in_item_t req);
    req_todo_q.push_back(req);
    reqs_queued++;
  endtask

  // A complete vertical-blank interrupt round: arm the display, program the
  // mask, let ticks raise status, read both status views, clear some bits and
  // read back. The control and mask slots follow the current variant.
  task automatic queue_vblank_round();
    logic [9:0]  ctrl_word;
    logic [9:0]  mask_word;
    logic [31:0] ctrl_data;
    ctrl_word = (cur_variant != lcdrf_pkg::VAR_BASE) ? lcdrf_pkg::REG_SLOT6
                                                     : lcdrf_pkg::REG_SLOT7;
    mask_word = (cur_variant != lcdrf_pkg::VAR_BASE) ? lcdrf_pkg::REG_SLOT7
                                                     : lcdrf_pkg::REG_SLOT6;
    ctrl_data = $urandom();
    if ($urandom_range(9, 0) < 8) ctrl_data = ctrl_data | CTRL_ON;
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {ctrl_word, 2'($urandom())}, ctrl_data));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {mask_word, 2'($urandom())}, $urandom()));
    repeat ($urandom_range(3, 1)) begin
      queue_req(make_req(lcdrf_pkg::CMD_TICK, 12'($urandom()), $urandom()));
    end
    queue_req(make_req(lcdrf_pkg::CMD_READ, {lcdrf_pkg::REG_RIS, 2'($urandom())}, $urandom()));
    queue_req(make_req(lcdrf_pkg::CMD_READ, {lcdrf_pkg::REG_MIS, 2'($urandom())}, $urandom()));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_ICR, 2'($urandom())}, $urandom()));
    queue_req(make_req(lcdrf_pkg::CMD_READ, {lcdrf_pkg::REG_RIS, 2'($urandom())}, $urandom()));
  endtask

  // Waits until no request is pending or in flight and every owed response
  // has arrived.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_todo_q.size() != 0 || in_valid_i || resp_due_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // The variant is only ever written while the block is idle.
  task automatic write_variant(input logic [1:0] v);
    @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_variant = v;
    @(negedge clk_i);
  endtask

  // Request driver. A beat that is offered stays put until it is accepted;
  // only then does the driver decide, by the idle rate, whether to offer the
  // next one. Acceptance is where the shadow model is advanced.
  always @(posedge clk_i) begin : drive_requests
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        resp_due_q.push_back(regfile_apply(req_todo_q.pop_front()));
      end
      if (!in_valid_i || !in_stall_o) begin
        offer = (req_todo_q.size() != 0) && ($urandom_range(99, 0) >= idle_pct);
        in_valid_i <= offer;
        if (offer) in_item_i <= req_todo_q[0];
      end
    end
  end

  // Response monitor. Every accepted beat is matched against the oldest owed
  // response, field by field; the stall for the next cycle is drawn once.
  always @(posedge clk_i) begin : check_responses
    lcdrf_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (resp_due_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("response beat with none owed: %h", out_item_o);
        end else begin
          want = resp_due_q.pop_front();
          if (out_item_o.read_data !== want.read_data || out_item_o.irq !== want.irq ||
              out_item_o.width_pixels !== want.width_pixels ||
              out_item_o.height_lines !== want.height_lines ||
              out_item_o.display_on !== want.display_on ||
              out_item_o.pixel_format !== want.pixel_format ||
              out_item_o.vblank_armed !== want.vblank_armed) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("response mismatch: expected rd=%h irq=%b w=%0d h=%0d on=%b fmt=%0d arm=%b",
                       want.read_data, want.irq, want.width_pixels, want.height_lines,
                       want.display_on, want.pixel_format, want.vblank_armed);
              $display("                   actual   rd=%h irq=%b w=%0d h=%0d on=%b fmt=%0d arm=%b",
                       out_item_o.read_data, out_item_o.irq, out_item_o.width_pixels,
                       out_item_o.height_lines, out_item_o.display_on,
                       out_item_o.pixel_format, out_item_o.vblank_armed);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_end;
    logic        held;
    int unsigned pick;
    logic [8:0]  pal_off;
    logic [9:0]  ctrl_word;
    logic [9:0]  mask_word;

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening under the base variant: geometry extremes, the full
    // vblank arm, tick, status and clear path, an unarmed tick, palette ends,
    // ID bytes, read-only and write-only words, an unused command and an
    // offset outside every window.
    write_variant(lcdrf_pkg::VAR_BASE);
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::REG_TIMING0, 2'b00}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_TIMING0, 2'b00}, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_TIMING0, 2'b11}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_TIMING1, 2'b01}, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_TIMING1, 2'b10}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_SLOT7, 2'b00},
                       CTRL_ON | 32'h0000_000e));
    queue_req(make_req(lcdrf_pkg::CMD_TICK,  12'hfff, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::REG_RIS, 2'b00}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_SLOT6, 2'b00}, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::REG_MIS, 2'b00}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_ICR, 2'b00},
                       {28'd0, lcdrf_pkg::STAT_NEXT_BASE}));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_ICR, 2'b00}, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_SLOT7, 2'b00}, 32'h0000_0001));
    queue_req(make_req(lcdrf_pkg::CMD_TICK,  12'h000, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::PAL_WINDOW, 9'h000}, 32'hdead_beef));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::PAL_WINDOW, 9'h1ff}, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::PAL_WINDOW, 9'h1fc}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::PAL_WINDOW, 9'h000}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::ID_WINDOW, 5'h00}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::ID_WINDOW, 5'h1f}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_RIS, 2'b00}, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::REG_ICR, 2'b00}, 32'd0));
    queue_req(make_req(CMD_UNUSED, 12'hfff, 32'hffff_ffff));
    queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_UPBASE, 2'b00}, 32'ha5a5_5a5a));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  {lcdrf_pkg::REG_UPCUR, 2'b00}, 32'd0));
    queue_req(make_req(lcdrf_pkg::CMD_READ,  12'h400, 32'd0));
    wait_idle();

    // Random phases, each setting a variant and its idle and stall rates. Halfway
    // through every phase the sender holds off until all owed responses are in.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_variant(lcdrf_pkg::VAR_EXTENDED); idle_pct = 0;  stall_pct = 0;  end
        1: begin write_variant(lcdrf_pkg::VAR_BOARD);    idle_pct = 56; stall_pct = 0;  end
        2: begin write_variant(VAR_SPARE);               idle_pct = 0;  stall_pct = 56; end
        3: begin write_variant(lcdrf_pkg::VAR_BASE);     idle_pct = 9;  stall_pct = 9;  end
        default: begin
          write_variant(lcdrf_pkg::VAR_EXTENDED); idle_pct = 0; stall_pct = 0;
        end
      endcase
      phase_end = reqs_queued + PHASE_REQS;
      held = 1'b0;
      while (reqs_queued < phase_end) begin
        pick = $urandom_range(99, 0);
        if (pick < 25) begin
          queue_vblank_round();
        end else if (pick < 40) begin
          // Palette write followed by a read of the same entry.
          pal_off = 9'($urandom());
          queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::PAL_WINDOW, pal_off},
                             rand_word()));
          queue_req(make_req(lcdrf_pkg::CMD_READ,
                             {lcdrf_pkg::PAL_WINDOW, pal_off[8:2], 2'($urandom())},
                             $urandom()));
        end else if (pick < 48) begin
          // Geometry writes then a readback of control and mask.
          ctrl_word = (cur_variant != lcdrf_pkg::VAR_BASE) ? lcdrf_pkg::REG_SLOT6
                                                           : lcdrf_pkg::REG_SLOT7;
          mask_word = (cur_variant != lcdrf_pkg::VAR_BASE) ? lcdrf_pkg::REG_SLOT7
                                                           : lcdrf_pkg::REG_SLOT6;
          queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_TIMING0, 2'($urandom())},
                             $urandom()));
          queue_req(make_req(lcdrf_pkg::CMD_WRITE, {lcdrf_pkg::REG_TIMING1, 2'($urandom())},
                             $urandom()));
          queue_req(make_req(lcdrf_pkg::CMD_READ, {ctrl_word, 2'($urandom())}, $urandom()));
          queue_req(make_req(lcdrf_pkg::CMD_READ, {mask_word, 2'($urandom())}, $urandom()));
        end else begin
          queue_req(rand_req());
        end
        if (!held && reqs_queued >= phase_end - PHASE_REQS / 2) begin
          wait_idle();
          held = 1'b1;
        end
      end
      wait_idle();
    end

    if (mismatch_cnt == 0 && resp_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
